[hw/rtl/osps_pkg.sv]
// ----------------------------------------------------------------------------
// osps_pkg: shared constants for the odd-only segmented prime sieve
// Widths, segment geometry and sequencer state codes.
// ----------------------------------------------------------------------------
package osps_pkg;

    localparam int LIMIT_W     = 32;
    localparam int SEG_NUM_W   = 19;
    localparam int SEG_WORDS   = 64;
    localparam int WORD_W      = 64;
    localparam int WOFF_W      = 6;
    localparam int SEG_BITS_W  = 12;                 // log2(64*64)
    localparam int MAX_BASE    = 8192;
    localparam int BASE_IDX_W  = 13;
    localparam int BASE_CNT_W  = 14;
    localparam int PRIME_W     = 16;
    localparam int SMALL_BITS  = 32768;              // odd numbers below 2^16
    localparam int SMALL_IDX_W = 15;
    localparam int SMALL_WORDS = SMALL_BITS / WORD_W;
    localparam int SMALL_WA_W  = 9;
    localparam int POS_W       = 32;                 // odd bit index width

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SQRT   = 5'd1;
    localparam logic [4:0] ST_SFILL  = 5'd2;
    localparam logic [4:0] ST_SPICK  = 5'd3;
    localparam logic [4:0] ST_SPRD   = 5'd4;
    localparam logic [4:0] ST_SCHK   = 5'd5;
    localparam logic [4:0] ST_SCRD   = 5'd6;
    localparam logic [4:0] ST_SCWR   = 5'd7;
    localparam logic [4:0] ST_SCOL   = 5'd8;
    localparam logic [4:0] ST_SCOLW  = 5'd9;
    localparam logic [4:0] ST_FILL   = 5'd10;
    localparam logic [4:0] ST_PRD    = 5'd11;
    localparam logic [4:0] ST_PDAT   = 5'd12;
    localparam logic [4:0] ST_DIV    = 5'd13;
    localparam logic [4:0] ST_FIRST  = 5'd14;
    localparam logic [4:0] ST_CRD    = 5'd15;
    localparam logic [4:0] ST_CWR    = 5'd16;
    localparam logic [4:0] ST_ORD    = 5'd17;
    localparam logic [4:0] ST_OUT    = 5'd18;
    localparam logic [4:0] ST_OOR    = 5'd19;
    localparam logic [4:0] ST_ODAT   = 5'd20;

endpackage

[hw/rtl/odd_segmented_prime_sieve.sv]
// ----------------------------------------------------------------------------
// odd_segmented_prime_sieve: odd-only segmented sieve of Eratosthenes
// Marks the primes among 4096 consecutive odd numbers per segment request.
// ----------------------------------------------------------------------------
// Usage:
//   sieve_limit_we/sieve_limit_wdata write the limit while the block is idle;
//   a write forces the base-prime table to be rebuilt before the next segment.
//   s_* channel: one transaction names a segment (bit i = odd number 2i+3).
//   m_* channel: 64 word transactions per in-range segment, last_word on the
//   final one; a segment past the limit gives one zero word with
//   beyond_range and last_word set, registered by the ST_OOR state that follows acceptance.
//   Segments: one at a time; s_ready is low from acceptance until the
//   last word transaction is taken. Per segment the sequencer fills the
//   map, then per base prime reads it from the table and starts the one
//   shared divider to compute its first multiple, clears each multiple
//   with a read then a write of the single map RAM port, and sends each
//   word out through ST_ORD, ST_ODAT and ST_OUT. The first in-range
//   segment after reset or a limit write also runs the small sieve that
//   builds the base table: an integer square root, a fill of the small
//   map, a read then write per small-map clear, and a scan of up to 32767 bits.
//   Reset: control state clears, the limit becomes 0, the table is marked
//   not ready. A stalled receiver simply holds the current word; the
//   sequencer waits on m_ready.
// ----------------------------------------------------------------------------
module odd_segmented_prime_sieve
    import osps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 sieve_limit_we,
    input  logic [LIMIT_W-1:0]   sieve_limit_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SEG_NUM_W-1:0] s_segment_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WOFF_W-1:0]    m_word_offset,
    output logic [WORD_W-1:0]    m_prime_bits,
    output logic                 m_last_word,
    output logic                 m_beyond_range
);

    logic [4:0]             state_reg, state_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic                   ready_tbl_reg, ready_tbl_next;
    logic [BASE_CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [POS_W-1:0]       start_reg, start_next;   // first bit index
    logic [POS_W:0]         stop_reg, stop_next;     // exclusive bit index
    logic [32:0]            odd_count;

    // isqrt / small-sieve registers
    logic [LIMIT_W-1:0]     sv_reg, sv_next;
    logic [LIMIT_W-1:0]     sroot_reg, sroot_next;   // wide while the root settles
    logic [LIMIT_W-1:0]     sbit_reg, sbit_next;
    logic [SMALL_IDX_W:0]   sidx_reg, sidx_next;     // also prime/scan cursor
    logic [SMALL_IDX_W:0]   stop_s_reg, stop_s_next; // count of small bits used
    logic [SMALL_IDX_W+1:0] sj_reg, sj_next;         // clear cursor (bit index)
    logic [PRIME_W:0]       sp_reg, sp_next;         // current small prime

    // segment walk registers
    logic [BASE_IDX_W:0]    pn_reg, pn_next;
    logic [PRIME_W-1:0]     p_reg, p_next;
    logic [33:0]            j_reg, j_next;           // absolute odd value
    logic [WOFF_W:0]        w_reg, w_next;
    logic [WORD_W-1:0]      obits_reg, obits_next;
    logic                   ovalid_reg, ovalid_next;
    logic [WOFF_W-1:0]      ooff_reg, ooff_next;
    logic                   olast_reg, olast_next;
    logic                   obeyond_reg, obeyond_next;

    // RAM ports
    logic                   sm_we, bt_we, seg_we;
    logic [SMALL_WA_W-1:0]  sm_addr;
    logic [WORD_W-1:0]      sm_wdata, sm_rdata;
    logic [BASE_IDX_W-1:0]  bt_addr;
    logic [PRIME_W-1:0]     bt_wdata, bt_rdata;
    logic [WOFF_W-1:0]      seg_addr;
    logic [WORD_W-1:0]      seg_wdata, seg_rdata;

    // divider
    logic                   div_start, div_done;
    logic [32:0]            div_dividend, div_q;

    logic [LIMIT_W-1:0]     sq_trial;
    logic [33:0]            seg_low, seg_last_odd, first_c, pp, jb;
    logic [POS_W-1:0]       bidx;
    logic [SEG_BITS_W-1:0]  rel;
    logic [POS_W:0]         wbase, remain;

    osps_ram #(.WIDTH(WORD_W), .DEPTH(SMALL_WORDS)) u_small (
        .aclk(aclk), .we(sm_we), .addr(sm_addr), .wdata(sm_wdata), .rdata(sm_rdata)
    );
    osps_ram #(.WIDTH(PRIME_W), .DEPTH(MAX_BASE)) u_base (
        .aclk(aclk), .we(bt_we), .addr(bt_addr), .wdata(bt_wdata), .rdata(bt_rdata)
    );
    osps_ram #(.WIDTH(WORD_W), .DEPTH(SEG_WORDS)) u_seg (
        .aclk(aclk), .we(seg_we), .addr(seg_addr), .wdata(seg_wdata), .rdata(seg_rdata)
    );
    osps_divu u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(p_reg), .done(div_done), .quotient(div_q)
    );

    assign odd_count    = (limit_reg >= 32'd3) ? ({1'b0, limit_reg - 32'd3} >> 1) + 33'd1 : '0;
    assign seg_low      = {1'b0, start_reg, 1'b0} + 34'd3;
    assign seg_last_odd = {stop_reg, 1'b0} + 34'd1;   // 2*(stop-1)+3
    assign pp           = {2'b00, p_reg} * {2'b00, p_reg};
    assign jb           = j_reg - 34'd3;
    assign bidx         = jb[POS_W:1];
    assign rel          = bidx[SEG_BITS_W-1:0] - start_reg[SEG_BITS_W-1:0];
    assign sq_trial     = sroot_reg + sbit_reg;
    assign div_dividend = seg_low[32:0] + {17'd0, p_reg} - 33'd1;
    assign wbase        = {1'b0, start_reg} +
                          {{(POS_W-WOFF_W-5){1'b0}}, w_reg[WOFF_W-1:0], 6'd0};
    assign remain       = stop_reg - wbase;

    assign s_ready        = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_valid        = ovalid_reg;
    assign m_word_offset  = ooff_reg;
    assign m_prime_bits   = obits_reg;
    assign m_last_word    = olast_reg;
    assign m_beyond_range = obeyond_reg;

    always_comb begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        ready_tbl_next = ready_tbl_reg;
        bcnt_next    = bcnt_reg;
        start_next   = start_reg;
        stop_next    = stop_reg;
        sv_next      = sv_reg;
        sroot_next   = sroot_reg;
        sbit_next    = sbit_reg;
        sidx_next    = sidx_reg;
        stop_s_next  = stop_s_reg;
        sj_next      = sj_reg;
        sp_next      = sp_reg;
        pn_next      = pn_reg;
        p_next       = p_reg;
        j_next       = j_reg;
        w_next       = w_reg;
        obits_next   = obits_reg;
        ovalid_next  = ovalid_reg;
        ooff_next    = ooff_reg;
        olast_next   = olast_reg;
        obeyond_next = obeyond_reg;
        sm_we = 1'b0; sm_addr = '0; sm_wdata = '0;
        bt_we = 1'b0; bt_addr = '0; bt_wdata = '0;
        seg_we = 1'b0; seg_addr = '0; seg_wdata = '0;
        div_start = 1'b0;
        first_c = '0;

        if (ovalid_reg && m_ready) begin
            ovalid_next = 1'b0;
        end
        if (sieve_limit_we) begin
            limit_next     = sieve_limit_wdata;
            ready_tbl_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    start_next = {1'b0, s_segment_number, 12'd0};
                    if ({2'b00, s_segment_number, 12'd0} >= odd_count) begin
                        state_next = ST_OOR;
                    end else begin
                        stop_next = ({2'b00, s_segment_number, 12'd0} + 33'd4096 > odd_count)
                                    ? odd_count : {2'b00, s_segment_number, 12'd0} + 33'd4096;
                        if (ready_tbl_reg) begin
                            w_next = '0;
                            state_next = ST_FILL;
                        end else begin
                            sv_next    = limit_reg;
                            sroot_next = '0;
                            sbit_next  = 32'h4000_0000;
                            bcnt_next  = '0;
                            state_next = ST_SQRT;
                        end
                    end
                end
            end
            ST_OOR: begin
                if (!ovalid_reg || m_ready) begin
                    ovalid_next = 1'b1; ooff_next = '0; obits_next = '0;
                    olast_next = 1'b1; obeyond_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SQRT: begin
                // one digit-pair of the integer square root per cycle
                if (sbit_reg == '0) begin
                    stop_s_next = (sroot_reg >= 32'd3)
                                  ? sroot_reg[SMALL_IDX_W+1:1] : '0; // sq/2 rounded down, (sq-3)/2+1 for odd sq
                    sidx_next  = '0;
                    state_next = ST_SFILL;
                end else begin
                    if (sv_reg >= sq_trial) begin
                        sv_next    = sv_reg - sq_trial;
                        sroot_next = (sroot_reg >> 1) + sbit_reg;
                    end else begin
                        sroot_next = sroot_reg >> 1;
                    end
                    sbit_next = sbit_reg >> 2;
                end
            end
            ST_SFILL: begin
                sm_we    = 1'b1;
                sm_addr  = sidx_reg[SMALL_WA_W-1:0];
                sm_wdata = '1;
                sidx_next = sidx_reg + 16'd1;
                if (sidx_reg == 16'(SMALL_WORDS - 1)) begin
                    sp_next    = 17'd3;
                    state_next = ST_SPICK;
                end
            end
            ST_SPICK: begin
                if ({15'd0, sp_reg} * {15'd0, sp_reg} > sroot_reg) begin
                    sidx_next  = '0;
                    state_next = ST_SCOL;
                end else begin
                    sm_addr    = 9'((sp_reg - 17'd3) >> 7);
                    state_next = ST_SPRD;
                end
            end
            ST_SPRD: begin
                sm_addr    = 9'((sp_reg - 17'd3) >> 7);
                state_next = ST_SCHK;
            end
            ST_SCHK: begin
                if (sm_rdata[6'((sp_reg - 17'd3) >> 1)]) begin
                    sj_next    = 17'(((sp_reg * sp_reg) - 17'd3) >> 1);
                    state_next = ST_SCRD;
                end else begin
                    sp_next    = sp_reg + 17'd2;
                    state_next = ST_SPICK;
                end
            end
            ST_SCRD: begin
                if ({14'd0, sj_reg, 1'b1} + 32'd2 > sroot_reg) begin
                    sp_next    = sp_reg + 17'd2;
                    state_next = ST_SPICK;
                end else begin
                    sm_addr    = sj_reg[SMALL_IDX_W-1:6];
                    state_next = ST_SCWR;
                end
            end
            ST_SCWR: begin
                sm_we    = 1'b1;
                sm_addr  = sj_reg[SMALL_IDX_W-1:6];
                sm_wdata = sm_rdata & ~(64'd1 << sj_reg[5:0]);
                sj_next  = sj_reg + sp_reg;
                state_next = ST_SCRD;
            end
            ST_SCOL: begin
                if (sidx_reg >= stop_s_reg) begin
                    ready_tbl_next = 1'b1;
                    w_next     = '0;
                    state_next = ST_FILL;
                end else begin
                    sm_addr    = sidx_reg[SMALL_IDX_W-1:6];
                    state_next = ST_SCOLW;
                end
            end
            ST_SCOLW: begin
                if (sm_rdata[sidx_reg[5:0]] && bcnt_reg < 14'(MAX_BASE)) begin
                    bt_we    = 1'b1;
                    bt_addr  = bcnt_reg[BASE_IDX_W-1:0];
                    bt_wdata = 16'({sidx_reg, 1'b1} + 17'd2);
                    bcnt_next = bcnt_reg + 14'd1;
                end
                sidx_next  = sidx_reg + 16'd1;
                state_next = ST_SCOL;
            end
            ST_FILL: begin
                seg_we    = 1'b1;
                seg_addr  = w_reg[WOFF_W-1:0];
                seg_wdata = '1;
                w_next    = w_reg + 7'd1;
                if (w_reg == 7'(SEG_WORDS - 1)) begin
                    pn_next    = '0;
                    state_next = ST_PRD;
                end
            end
            ST_PRD: begin
                if (pn_reg >= bcnt_reg) begin
                    w_next     = '0;
                    state_next = ST_ORD;
                end else begin
                    bt_addr    = pn_reg[BASE_IDX_W-1:0];
                    state_next = ST_PDAT;
                end
            end
            ST_PDAT: begin
                p_next     = bt_rdata;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                div_start  = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                if (div_done) begin
                    first_c = {1'b0, div_q} * {18'd0, p_reg};
                    if (!first_c[0]) first_c = first_c + {18'd0, p_reg};
                    if (first_c < pp) first_c = pp;
                    j_next     = first_c;
                    state_next = ST_CRD;
                end
            end
            ST_CRD: begin
                if (j_reg > seg_last_odd) begin
                    pn_next    = pn_reg + 14'd1;
                    state_next = ST_PRD;
                end else begin
                    seg_addr   = rel[SEG_BITS_W-1:6];
                    state_next = ST_CWR;
                end
            end
            ST_CWR: begin
                seg_we    = 1'b1;
                seg_addr  = rel[SEG_BITS_W-1:6];
                seg_wdata = seg_rdata & ~(64'd1 << rel[5:0]);
                j_next    = j_reg + {17'd0, p_reg, 1'b0};
                state_next = ST_CRD;
            end
            ST_ORD: begin
                seg_addr   = w_reg[WOFF_W-1:0];
                state_next = ST_ODAT;
            end
            ST_ODAT: begin
                seg_addr   = w_reg[WOFF_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // keep the address so the read data survives a stall
                seg_addr = w_reg[WOFF_W-1:0];
                if (!ovalid_reg || m_ready) begin
                    ovalid_next  = 1'b1;
                    ooff_next    = w_reg[WOFF_W-1:0];
                    olast_next   = (w_reg == 7'(SEG_WORDS - 1));
                    obeyond_next = 1'b0;
                    if (wbase >= stop_reg)        obits_next = '0;
                    else if (remain < 33'd64)     obits_next = seg_rdata &
                                                   ((64'd1 << remain[5:0]) - 64'd1);
                    else                          obits_next = seg_rdata;
                    w_next = w_reg + 7'd1;
                    state_next = (w_reg == 7'(SEG_WORDS - 1)) ? ST_IDLE : ST_ORD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            limit_reg     <= '0;
            ready_tbl_reg <= 1'b0;
            bcnt_reg      <= '0;
            ovalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            ready_tbl_reg <= ready_tbl_next;
            bcnt_reg      <= bcnt_next;
            ovalid_reg    <= ovalid_next;
        end
        start_reg   <= start_next;
        stop_reg    <= stop_next;
        sv_reg      <= sv_next;
        sroot_reg   <= sroot_next;
        sbit_reg    <= sbit_next;
        sidx_reg    <= sidx_next;
        stop_s_reg  <= stop_s_next;
        sj_reg      <= sj_next;
        sp_reg      <= sp_next;
        pn_reg      <= pn_next;
        p_reg       <= p_next;
        j_reg       <= j_next;
        w_reg       <= w_next;
        obits_reg   <= obits_next;
        ooff_reg    <= ooff_next;
        olast_reg   <= olast_next;
        obeyond_reg <= obeyond_next;
    end

endmodule

[hw/rtl/osps_ram.sv]
// ----------------------------------------------------------------------------
// osps_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module osps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/osps_divu.sv]
// ----------------------------------------------------------------------------
// osps_divu: radix-2 restoring divider
// Unsigned 33-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module osps_divu
    import osps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [32:0]        dividend,
    input  logic [PRIME_W-1:0] divisor,
    output logic               done,
    output logic [32:0]        quotient
);

    logic [32:0]        q_reg, q_next;
    logic [PRIME_W:0]   r_reg, r_next;
    logic [PRIME_W-1:0] d_reg, d_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [PRIME_W+1:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = {r_reg, q_reg[32]} - {2'b00, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[PRIME_W+1]) begin
                r_next = trial[PRIME_W:0];
                q_next = {q_reg[31:0], 1'b1};
            end else begin
                r_next = {r_reg[PRIME_W-1:0], q_reg[32]};
                q_next = {q_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = q_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

endmodule
